// File: hdl/hss_pkg.sv
// ----------------------------------------------------------------------------
// hss_pkg
// Types, widths and the half-step coil table shared by the stepper sequencer.
// ----------------------------------------------------------------------------
package hss_pkg;

  localparam int TIMER_BITS = 32;
  localparam int PERIOD_W   = 32;
  localparam int POS_W      = 15;
  localparam int STEPS_W    = 16;
  localparam int COIL_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RESET   = 32'd1000;
  localparam logic [POS_W-1:0]    STEPS_PER_REV_RESET = 15'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_PERIOD   = 2'd0,
    CFG_STEPS_PER_REV = 2'd1
  } cfg_index_t;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_MOVE = 1'b1
  } command_t;

  typedef struct packed {
    logic               command;
    logic signed [15:0] move_steps;
  } cmd_item_t;

  typedef struct packed {
    logic [COIL_W-1:0] coils;
    logic [POS_W-1:0]  position;
    logic              moving_forward;
    logic [POS_W-1:0]  remaining;
    logic              stepped;
    logic              busy_res;
  } res_item_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] step_period;
    logic [POS_W-1:0]    steps_per_rev;
  } cfg_regs_t;

  // Eight-phase half-step order: one coil, two adjacent coils, and so on.
  function automatic logic [COIL_W-1:0] half_step_coils(input logic [2:0] phase);
    logic [COIL_W-1:0] pattern;
    case (phase)
      3'd0:    pattern = 4'h1;
      3'd1:    pattern = 4'h3;
      3'd2:    pattern = 4'h2;
      3'd3:    pattern = 4'h6;
      3'd4:    pattern = 4'h4;
      3'd5:    pattern = 4'hC;
      3'd6:    pattern = 4'h8;
      default: pattern = 4'h9;
    endcase
    return pattern;
  endfunction

endpackage

// File: hdl/hss_step_unit.sv
// ----------------------------------------------------------------------------
// hss_step_unit
// Motion state of the sequencer and the single-pass update for one request.
// ----------------------------------------------------------------------------
module hss_step_unit
  import hss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  cmd_item_t item,
  input  cfg_regs_t cfg,
  output res_item_t result
);

  logic [POS_W-1:0]      position_count, position_count_next;
  logic [POS_W-1:0]      steps_to_go, steps_to_go_next;
  logic                  forward_flag, forward_flag_next;
  logic [TIMER_BITS-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [COIL_W-1:0]     coil_pattern, coil_pattern_next;

  logic [TIMER_BITS-1:0] elapsed_inc;
  logic [POS_W-1:0]      revs;
  logic [POS_W-1:0]      step_pos;
  logic [STEPS_W-1:0]    magnitude;
  logic                  do_step;

  always_comb begin
    revs        = (cfg.steps_per_rev == '0) ? POS_W'(1) : cfg.steps_per_rev;
    elapsed_inc = (elapsed_ticks == TIMER_MAX) ? elapsed_ticks
                                               : elapsed_ticks + TIMER_BITS'(1);
    do_step     = (item.command == CMD_TICK) && (steps_to_go != '0) &&
                  (elapsed_inc >= TIMER_BITS'(cfg.step_period));
    magnitude   = STEPS_W'(-item.move_steps);

    // A position left outside a shortened revolution re-enters at an end.
    if (forward_flag) begin
      if ({1'b0, position_count} + 16'd1 >= {1'b0, revs}) begin
        step_pos = '0;
      end else begin
        step_pos = position_count + POS_W'(1);
      end
    end else begin
      if ((position_count == '0) || (position_count >= revs)) begin
        step_pos = revs - POS_W'(1);
      end else begin
        step_pos = position_count - POS_W'(1);
      end
    end

    position_count_next = position_count;
    steps_to_go_next    = steps_to_go;
    forward_flag_next   = forward_flag;
    elapsed_ticks_next  = elapsed_ticks;
    coil_pattern_next   = coil_pattern;

    if (item.command == CMD_MOVE) begin
      if (item.move_steps == '0) begin
        steps_to_go_next = '0;
      end else if (item.move_steps[STEPS_W-1]) begin
        forward_flag_next = 1'b0;
        // The most negative count has no positive twin and saturates.
        steps_to_go_next  = magnitude[STEPS_W-1] ? '1 : magnitude[POS_W-1:0];
      end else begin
        forward_flag_next = 1'b1;
        steps_to_go_next  = item.move_steps[POS_W-1:0];
      end
    end else begin
      elapsed_ticks_next = elapsed_inc;
      if (do_step) begin
        elapsed_ticks_next  = '0;
        position_count_next = step_pos;
        steps_to_go_next    = steps_to_go - POS_W'(1);
        coil_pattern_next   = half_step_coils(step_pos[2:0]);
      end
    end

    result.coils          = coil_pattern_next;
    result.position       = position_count_next;
    result.moving_forward = forward_flag_next;
    result.remaining      = steps_to_go_next;
    result.stepped        = do_step;
    result.busy_res       = (steps_to_go_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      steps_to_go    <= '0;
      forward_flag   <= 1'b0;
      elapsed_ticks  <= TIMER_MAX;
      coil_pattern   <= '0;
    end else if (advance) begin
      position_count <= position_count_next;
      steps_to_go    <= steps_to_go_next;
      forward_flag   <= forward_flag_next;
      elapsed_ticks  <= elapsed_ticks_next;
      coil_pattern   <= coil_pattern_next;
    end
  end

endmodule

// File: hdl/hss_out_reg.sv
// ----------------------------------------------------------------------------
// hss_out_reg
// Result register that holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module hss_out_reg
  import hss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  res_item_t load_item,
  output logic      can_load,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res_item
);

  assign can_load = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (can_load) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      res_item <= load_item;
    end
  end

endmodule

// File: hdl/half_step_stepper_sequencer.sv
// ----------------------------------------------------------------------------
// half_step_stepper_sequencer
// Eight-phase half-step sequencer for a four-coil unipolar stepper motor.
//
// Each request is either a one-microsecond tick or a move carrying a signed
// step count, and each gives exactly one result with the coil drive, position,
// direction and remaining steps after it. A request passes through an input
// register and is resolved combinationally into the result register, so one
// request is taken every clock while results are taken. step_period and
// steps_per_rev are written through the plain register port; the user must
// write them only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module half_step_stepper_sequencer
  import hss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  cmd_item_t             cmd_item,
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_item_t             res_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_regs_t cfg;
  logic      hold_valid;
  cmd_item_t hold_item;
  logic      can_load;
  logic      advance;
  res_item_t step_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_period   <= STEP_PERIOD_RESET;
      cfg.steps_per_rev <= STEPS_PER_REV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_PERIOD:   cfg.step_period   <= cfg_data[PERIOD_W-1:0];
        CFG_STEPS_PER_REV: cfg.steps_per_rev <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance   = hold_valid && can_load;
  assign cmd_ready = !hold_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (cmd_ready) begin
      hold_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      hold_item <= cmd_item;
    end
  end

  hss_step_unit u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (hold_item),
    .cfg     (cfg),
    .result  (step_result)
  );

  hss_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (hold_valid),
    .load_item (step_result),
    .can_load  (can_load),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

endmodule

// File: hdl/hss_checker.sv
// ----------------------------------------------------------------------------
// hss_checker
// Port-level assertions for the stepper sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module hss_checker
  import hss_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      res_valid,
  input logic      res_ready,
  input res_item_t res_item
);

  // A result offered and not taken stays, unchanged.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_item))
    else $error("result changed or vanished while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_item.busy_res == (res_item.remaining != '0)))
    else $error("busy flag disagrees with remaining steps");

  // Every table entry drives at least one coil.
  a_step_coils: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.stepped |-> (res_item.coils != '0))
    else $error("step left all coils off");

  a_position: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_item.position != '1))
    else $error("position beyond the largest revolution");

  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result offered straight after reset");

endmodule

bind half_step_stepper_sequencer hss_checker u_hss_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_item  (res_item)
);
